[design/assert_macros.svh]
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[design/sha1e_pkg.sv]
package sha1e_pkg;

    localparam int SHA1E_QUEUE_DEPTH = 2;
    localparam int NUM_CHAIN         = 5;
    localparam int BLOCK_WORDS       = 16;
    localparam int NUM_ROUNDS        = 80;

    typedef logic [31:0] word_t;

    localparam word_t K_R0 = 32'h5A827999;
    localparam word_t K_R1 = 32'h6ED9EBA1;
    localparam word_t K_R2 = 32'h8F1BBCDC;
    localparam word_t K_R3 = 32'hCA62C1D6;

    localparam word_t H_INIT0 = 32'h67452301;
    localparam word_t H_INIT1 = 32'hefcdab89;
    localparam word_t H_INIT2 = 32'h98badcfe;
    localparam word_t H_INIT3 = 32'h10325476;
    localparam word_t H_INIT4 = 32'hc3d2e1f0;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam word_t PAD_MARK = {PAD_BYTE, 24'h000000};

    typedef enum logic [1:0] {
        KIND_WORD,
        KIND_LAST_FULL,
        KIND_LAST_PART
    } kind_t;

    typedef struct packed {
        word_t       data;
        kind_t       kind;
        logic [2:0]  nbytes;
    } qentry_t;

    typedef enum logic [2:0] {
        ST_TAKE,
        ST_MARK,
        ST_PAD,
        ST_LEN_LO,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } state_t;

    function automatic word_t init_word(input logic [2:0] idx);
        word_t w;
        case (idx)
            3'd0: w = H_INIT0;
            3'd1: w = H_INIT1;
            3'd2: w = H_INIT2;
            3'd3: w = H_INIT3;
            3'd4: w = H_INIT4;
            default: w = H_INIT0;
        endcase
        return w;
    endfunction

endpackage

[design/sha1_hash_engine_unit.sv]
// sha-1 hash engine
// input channel (s_): one message word per transaction, big-endian, with
// s_byte_count valid bytes (high-order first) and s_last_word on the final
// word; byte count matters only on the last word, values above four act as four
// result channel (m_): five transactions per message carrying the digest,
// m_word_index 0 (most significant) to 4, m_last_digest on index 4
// a two-entry input queue lets the sender run ahead of the compression core
// words enter the block buffer one at a time; every sixteenth word starts a
// compression (80 rounds at one per cycle, then the chaining add), during which
// the core takes no words from the queue
// after the last word the core pads (up to two blocks of 16 words),
// compresses once or twice, then presents the digest words at one per cycle
// while the receiver is ready; the core then takes the next message
// reset (aresetn low at a clock edge) empties the queue, restores the initial
// chaining value and clears the bit count
// a stalled receiver holds the current digest word; the queue keeps
// accepting words until it fills
module sha1_hash_engine_unit #(
    parameter int QUEUE_DEPTH = sha1e_pkg::SHA1E_QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_data_word,
    input  logic [2:0]  s_byte_count,
    input  logic        s_last_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_last_digest
);

    logic               q_valid;
    logic               q_pop;
    sha1e_pkg::qentry_t q_entry;

    sha1e_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_word  (s_data_word),
        .s_byte_count (s_byte_count),
        .s_last_word  (s_last_word),
        .q_valid      (q_valid),
        .q_entry      (q_entry),
        .q_pop        (q_pop)
    );

    sha1e_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_entry       (q_entry),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_digest_word (m_digest_word),
        .m_word_index  (m_word_index),
        .m_last_digest (m_last_digest)
    );

endmodule

[design/sha1e_front.sv]
module sha1e_front #(
    parameter int QUEUE_DEPTH = sha1e_pkg::SHA1E_QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [31:0]       s_data_word,
    input  logic [2:0]        s_byte_count,
    input  logic              s_last_word,
    output logic              q_valid,
    output sha1e_pkg::qentry_t q_entry,
    input  logic              q_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    sha1e_pkg::qentry_t queue_mem [QUEUE_DEPTH];
    sha1e_pkg::qentry_t in_entry;

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [2:0]       cnt_sat;
    logic             push, pop;

    // classify: saturate count, mask unused bytes, place pad marker
    always_comb begin
        cnt_sat = (s_byte_count > 3'd4) ? 3'd4 : s_byte_count;
        in_entry.data   = s_data_word;
        in_entry.kind   = sha1e_pkg::KIND_WORD;
        in_entry.nbytes = 3'd4;
        if (s_last_word) begin
            in_entry.nbytes = cnt_sat;
            if (cnt_sat == 3'd4) begin
                in_entry.kind = sha1e_pkg::KIND_LAST_FULL;
            end else begin
                in_entry.kind = sha1e_pkg::KIND_LAST_PART;
                case (cnt_sat)
                    3'd0: in_entry.data = sha1e_pkg::PAD_MARK;
                    3'd1: in_entry.data = {s_data_word[31:24], sha1e_pkg::PAD_BYTE, 16'h0000};
                    3'd2: in_entry.data = {s_data_word[31:16], sha1e_pkg::PAD_BYTE, 8'h00};
                    3'd3: in_entry.data = {s_data_word[31:8], sha1e_pkg::PAD_BYTE};
                    default: in_entry.data = s_data_word;
                endcase
            end
        end
    end

    assign s_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_entry = queue_mem[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        case ({push, pop})
            2'b10: count_next = count_reg + CNT_W'(1);
            2'b01: count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_mem[wr_ptr_reg] <= in_entry;
        end
    end

endmodule

[design/sha1e_back.sv]
module sha1e_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  sha1e_pkg::qentry_t q_entry,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [31:0]        m_digest_word,
    output logic [2:0]         m_word_index,
    output logic               m_last_digest
);

    sha1e_pkg::state_t state_reg, state_next;
    sha1e_pkg::state_t ret_reg, ret_next;
    sha1e_pkg::state_t after_push;

    sha1e_pkg::word_t chain_reg [sha1e_pkg::NUM_CHAIN];
    sha1e_pkg::word_t work_reg  [sha1e_pkg::NUM_CHAIN];
    sha1e_pkg::word_t sched_reg [sha1e_pkg::BLOCK_WORDS];

    logic [3:0]  wib_reg;
    logic [6:0]  round_reg;
    logic [63:0] bits_reg;
    logic [2:0]  dig_idx_reg;

    logic        m_valid_reg;
    logic [31:0] out_word_reg;
    logic [2:0]  out_idx_reg;
    logic        out_last_reg;

    logic             push_en;
    sha1e_pkg::word_t push_word;
    logic             load_out;
    logic             block_full;

    sha1e_pkg::word_t rnd_f, rnd_k, rnd_t, sched_new, sched_mix;

    assign block_full = (wib_reg == 4'(sha1e_pkg::BLOCK_WORDS - 1));

    // output decode
    always_comb begin
        push_en   = 1'b0;
        push_word = '0;
        q_pop     = 1'b0;
        load_out  = 1'b0;
        case (state_reg)
            sha1e_pkg::ST_TAKE: begin
                if (q_valid) begin
                    q_pop     = 1'b1;
                    push_en   = 1'b1;
                    push_word = q_entry.data;
                end
            end
            sha1e_pkg::ST_MARK: begin
                push_en   = 1'b1;
                push_word = sha1e_pkg::PAD_MARK;
            end
            sha1e_pkg::ST_PAD: begin
                push_en   = 1'b1;
                push_word = (wib_reg == 4'd14) ? bits_reg[63:32] : '0;
            end
            sha1e_pkg::ST_LEN_LO: begin
                push_en   = 1'b1;
                push_word = bits_reg[31:0];
            end
            sha1e_pkg::ST_OUT: begin
                load_out = !m_valid_reg || m_ready;
            end
            default: begin
                push_en = 1'b0;
            end
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        after_push = state_reg;
        case (state_reg)
            sha1e_pkg::ST_TAKE: begin
                case (q_entry.kind)
                    sha1e_pkg::KIND_LAST_FULL: after_push = sha1e_pkg::ST_MARK;
                    sha1e_pkg::KIND_LAST_PART: after_push = sha1e_pkg::ST_PAD;
                    default:                   after_push = sha1e_pkg::ST_TAKE;
                endcase
            end
            sha1e_pkg::ST_MARK:   after_push = sha1e_pkg::ST_PAD;
            sha1e_pkg::ST_PAD:    after_push = (wib_reg == 4'd14) ? sha1e_pkg::ST_LEN_LO
                                                                  : sha1e_pkg::ST_PAD;
            sha1e_pkg::ST_LEN_LO: after_push = sha1e_pkg::ST_OUT;
            default:              after_push = state_reg;
        endcase
        case (state_reg)
            sha1e_pkg::ST_ROUND: begin
                if (round_reg == 7'(sha1e_pkg::NUM_ROUNDS - 1)) begin
                    state_next = sha1e_pkg::ST_ADD;
                end
            end
            sha1e_pkg::ST_ADD: begin
                state_next = ret_reg;
            end
            sha1e_pkg::ST_OUT: begin
                if (load_out && dig_idx_reg == 3'(sha1e_pkg::NUM_CHAIN - 1)) begin
                    state_next = sha1e_pkg::ST_TAKE;
                end
            end
            default: begin
                if (push_en) begin
                    if (block_full) begin
                        state_next = sha1e_pkg::ST_ROUND;
                        ret_next   = after_push;
                    end else begin
                        state_next = after_push;
                    end
                end
            end
        endcase
    end

    // round function
    always_comb begin
        if (round_reg < 7'd20) begin
            rnd_f = (work_reg[1] & work_reg[2]) | (~work_reg[1] & work_reg[3]);
            rnd_k = sha1e_pkg::K_R0;
        end else if (round_reg < 7'd40) begin
            rnd_f = work_reg[1] ^ work_reg[2] ^ work_reg[3];
            rnd_k = sha1e_pkg::K_R1;
        end else if (round_reg < 7'd60) begin
            rnd_f = (work_reg[1] & work_reg[2]) | (work_reg[1] & work_reg[3])
                  | (work_reg[2] & work_reg[3]);
            rnd_k = sha1e_pkg::K_R2;
        end else begin
            rnd_f = work_reg[1] ^ work_reg[2] ^ work_reg[3];
            rnd_k = sha1e_pkg::K_R3;
        end
        rnd_t = {work_reg[0][26:0], work_reg[0][31:27]} + rnd_f + work_reg[4]
              + rnd_k + sched_reg[0];
        sched_mix = sched_reg[13] ^ sched_reg[8] ^ sched_reg[2] ^ sched_reg[0];
        sched_new = {sched_mix[30:0], sched_mix[31]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sha1e_pkg::ST_TAKE;
            ret_reg     <= sha1e_pkg::ST_TAKE;
            wib_reg     <= '0;
            round_reg   <= '0;
            bits_reg    <= '0;
            dig_idx_reg <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < sha1e_pkg::NUM_CHAIN; i++) begin
                chain_reg[i] <= sha1e_pkg::init_word(3'(i));
            end
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            if (push_en) begin
                wib_reg <= wib_reg + 4'd1;
            end
            if (q_pop) begin
                bits_reg <= bits_reg + {58'd0, q_entry.nbytes, 3'b000};
            end
            if (state_reg == sha1e_pkg::ST_ROUND) begin
                round_reg <= (round_reg == 7'(sha1e_pkg::NUM_ROUNDS - 1)) ? '0
                                                                         : round_reg + 7'd1;
            end
            if (state_reg == sha1e_pkg::ST_ADD) begin
                for (int i = 0; i < sha1e_pkg::NUM_CHAIN; i++) begin
                    chain_reg[i] <= chain_reg[i] + work_reg[i];
                end
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
                if (dig_idx_reg == 3'(sha1e_pkg::NUM_CHAIN - 1)) begin
                    dig_idx_reg <= '0;
                    bits_reg    <= '0;
                    for (int i = 0; i < sha1e_pkg::NUM_CHAIN; i++) begin
                        chain_reg[i] <= sha1e_pkg::init_word(3'(i));
                    end
                end else begin
                    dig_idx_reg <= dig_idx_reg + 3'd1;
                end
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push_en) begin
            for (int i = 0; i < sha1e_pkg::BLOCK_WORDS - 1; i++) begin
                sched_reg[i] <= sched_reg[i + 1];
            end
            sched_reg[sha1e_pkg::BLOCK_WORDS - 1] <= push_word;
        end else if (state_reg == sha1e_pkg::ST_ROUND) begin
            for (int i = 0; i < sha1e_pkg::BLOCK_WORDS - 1; i++) begin
                sched_reg[i] <= sched_reg[i + 1];
            end
            sched_reg[sha1e_pkg::BLOCK_WORDS - 1] <= sched_new;
        end
        if (push_en && block_full) begin
            for (int i = 0; i < sha1e_pkg::NUM_CHAIN; i++) begin
                work_reg[i] <= chain_reg[i];
            end
        end else if (state_reg == sha1e_pkg::ST_ROUND) begin
            work_reg[0] <= rnd_t;
            work_reg[1] <= work_reg[0];
            work_reg[2] <= {work_reg[1][1:0], work_reg[1][31:2]};
            work_reg[3] <= work_reg[2];
            work_reg[4] <= work_reg[3];
        end
        if (load_out) begin
            out_word_reg <= chain_reg[dig_idx_reg];
            out_idx_reg  <= dig_idx_reg;
            out_last_reg <= (dig_idx_reg == 3'(sha1e_pkg::NUM_CHAIN - 1));
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_digest_word = out_word_reg;
    assign m_word_index  = out_idx_reg;
    assign m_last_digest = out_last_reg;

endmodule

[design/sha1e_checker.sv]
`include "assert_macros.svh"

module sha1e_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_digest_word,
    input logic [2:0]  m_word_index,
    input logic        m_last_digest
);

    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_digest_word) && $stable(m_word_index) && $stable(m_last_digest))
    `ASSERT_IMPLY(a_last_at_four, aclk, aresetn, m_valid, m_last_digest == (m_word_index == 3'd4))
    `ASSERT_NEXT(a_index_step, aclk, aresetn, m_valid && m_ready && !m_last_digest, m_valid && (m_word_index == $past(m_word_index) + 3'd1))
    `ASSERT_IMPLY(a_digest_starts, aclk, aresetn, $rose(m_valid), m_word_index == 3'd0)

endmodule

bind sha1_hash_engine_unit sha1e_checker u_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_digest_word (m_digest_word),
    .m_word_index  (m_word_index),
    .m_last_digest (m_last_digest)
);
